FILE: src/max_heap_priority_queue_defines.svh
// Assertion macros used by the checker file.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define HMPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define HMPQ_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/hmpq_pkg.sv
`default_nettype none

package hmpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ID_W         = 16;
    localparam int PRIO_W       = 16;
    localparam int S_TDATA_W    = ID_W + PRIO_W;

    // one heap slot: id in the upper half, priority in the lower
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STS_INSERTED  = 2'd0,
        STS_EXTRACTED = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WR,
        S_EXT_RD,
        S_EXT_ROOT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RB_INIT,
        S_SIFT_RD,
        S_SIFT_LD,
        S_SIFT_CMP,
        S_SIFT_WR,
        S_RESULT
    } fsm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic ins_wr;
        logic ext_rd;
        logic ext_root;
        logic shift_rd;
        logic shift_wr;
        logic cnt_dec;
        logic rb_init;
        logic sift_rd;
        logic sift_ld;
        logic sift_cmp;
        logic sift_wr;
        logic next_idx;
        logic load_result;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_extract;
        logic full;
        logic empty;
        logic shift_done;
        logic lt_two;
        logic moved;
        logic deeper;
        logic idx_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/hmpq_ram.sv
`default_nettype none

module hmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: src/hmpq_ctrl.sv
`default_nettype none

module hmpq_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire hmpq_pkg::dp_stat_t   stat,
    output hmpq_pkg::ctrl_cmd_t       cmd
);
    import hmpq_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (stat.is_extract) begin
                    state_next = stat.empty ? S_RESULT : S_EXT_RD;
                end else begin
                    state_next = stat.full ? S_RESULT : S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.ins_wr = 1'b1;
                state_next = S_RB_INIT;
            end
            S_EXT_RD: begin
                cmd.ext_rd = 1'b1;
                state_next = S_EXT_ROOT;
            end
            S_EXT_ROOT: begin
                cmd.ext_root = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                if (stat.shift_done) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RB_INIT;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_RB_INIT: begin
                cmd.rb_init = 1'b1;
                state_next  = stat.lt_two ? S_RESULT : S_SIFT_RD;
            end
            S_SIFT_RD: begin
                cmd.sift_rd = 1'b1;
                state_next  = S_SIFT_LD;
            end
            S_SIFT_LD: begin
                cmd.sift_ld = 1'b1;
                state_next  = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                cmd.sift_cmp = 1'b1;
                if (stat.moved) begin
                    state_next = stat.deeper ? S_SIFT_CMP : S_SIFT_WR;
                end else if (stat.idx_zero) begin
                    state_next = S_RESULT;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = S_SIFT_RD;
                end
            end
            S_SIFT_WR: begin
                cmd.sift_wr = 1'b1;
                if (stat.idx_zero) begin
                    state_next = S_RESULT;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = S_SIFT_RD;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/hmpq_datapath.sv
`default_nettype none

module hmpq_datapath #(
    parameter int CAPACITY  = hmpq_pkg::DEF_CAPACITY,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((32 + CNT_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [hmpq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [M_TDATA_W-1:0]           m_tdata,
    output logic      [1:0]                     m_tuser,
    input  wire hmpq_pkg::ctrl_cmd_t            cmd,
    output hmpq_pkg::dp_stat_t                  stat
);
    import hmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int XW = CNT_W + 1;
    localparam int EW = $bits(entry_t);

    cmd_t                 in_cmd_reg;
    entry_t               in_entry_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     src_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        pos_reg;
    entry_t               cur_reg;
    status_t              sts_reg;
    logic [ID_W-1:0]      oid_reg;
    logic [PRIO_W-1:0]    opr_reg;

    logic                 m_valid_reg;
    status_t              m_sts_reg;
    logic [ID_W-1:0]      m_id_reg;
    logic [PRIO_W-1:0]    m_prio_reg;
    logic [CNT_W-1:0]     m_occ_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [EW-1:0]        ram_rdata_a;
    logic [EW-1:0]        ram_rdata_b;
    entry_t               rd_a;
    entry_t               rd_b;

    logic [XW-1:0]        count_x;
    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        left_x;
    logic [XW-1:0]        right_x;
    logic                 left_ok;
    logic                 right_ok;
    entry_t               best_e;
    logic [XW-1:0]        best_x;
    logic [XW-1:0]        best_left_x;
    logic [XW-1:0]        best_right_x;
    logic                 moved;
    logic [CNT_W-1:0]     src_m1;
    logic [CNT_W-1:0]     cnt_half;

    assign rd_a = entry_t'(ram_rdata_a);
    assign rd_b = entry_t'(ram_rdata_b);

    hmpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // children of the current sift position
    assign count_x  = XW'(count_reg);
    assign pos_x    = XW'(pos_reg);
    assign left_x   = (pos_x << 1) + XW'(1);
    assign right_x  = left_x + XW'(1);
    assign left_ok  = left_x < count_x;
    assign right_ok = right_x < count_x;

    // strict greater-than, left child wins a tie
    always_comb begin
        best_e = cur_reg;
        best_x = pos_x;
        moved  = 1'b0;
        if (left_ok && (rd_a.prio > cur_reg.prio)) begin
            best_e = rd_a;
            best_x = left_x;
            moved  = 1'b1;
        end
        if (right_ok && (rd_b.prio > best_e.prio)) begin
            best_e = rd_b;
            best_x = right_x;
            moved  = 1'b1;
        end
    end

    assign best_left_x  = (best_x << 1) + XW'(1);
    assign best_right_x = best_left_x + XW'(1);
    assign src_m1       = src_reg - CNT_W'(1);
    assign cnt_half     = (count_reg - CNT_W'(1)) >> 1;

    // write port: append, shift, or sift (child moves up / hole filled)
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = cur_reg;
        if (cmd.ins_wr) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = in_entry_reg;
        end else if (cmd.shift_wr) begin
            ram_we    = 1'b1;
            ram_waddr = src_m1[AW-1:0];
            ram_wdata = rd_a;
        end else if (cmd.sift_cmp) begin
            ram_we    = 1'b1;
            ram_wdata = moved ? best_e : cur_reg;
        end else if (cmd.sift_wr) begin
            ram_we    = 1'b1;
        end
    end

    always_comb begin
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        if (cmd.ext_rd) begin
            // root
            ram_raddr_a = '0;
        end else if (cmd.shift_rd) begin
            ram_raddr_a = src_reg[AW-1:0];
        end else if (cmd.sift_rd) begin
            ram_raddr_a = idx_reg;
        end else if (cmd.sift_ld) begin
            ram_raddr_a = left_x[AW-1:0];
            ram_raddr_b = right_x[AW-1:0];
        end else if (cmd.sift_cmp) begin
            ram_raddr_a = best_left_x[AW-1:0];
            ram_raddr_b = best_right_x[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_cmd_reg        <= cmd_t'(s_tuser);
            in_entry_reg.id   <= s_tdata[ID_W-1:0];
            in_entry_reg.prio <= s_tdata[ID_W +: PRIO_W];
        end
        if (cmd.decode) begin
            oid_reg <= '0;
            opr_reg <= '0;
            if (in_cmd_reg == CMD_EXTRACT) begin
                sts_reg <= stat.empty ? STS_EMPTY : STS_EXTRACTED;
            end else begin
                sts_reg <= stat.full ? STS_FULL : STS_INSERTED;
            end
        end
        if (cmd.ext_root) begin
            oid_reg <= rd_a.id;
            opr_reg <= rd_a.prio;
            src_reg <= CNT_W'(1);
        end
        if (cmd.shift_wr) begin
            src_reg <= src_reg + CNT_W'(1);
        end
        if (cmd.rb_init) begin
            idx_reg <= cnt_half[AW-1:0];
        end
        if (cmd.next_idx) begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (cmd.sift_rd) begin
            pos_reg <= idx_reg;
        end
        if (cmd.sift_ld) begin
            cur_reg <= rd_a;
        end
        if (cmd.sift_cmp && moved) begin
            pos_reg <= best_x[AW-1:0];
        end
        if (cmd.load_result) begin
            m_sts_reg  <= sts_reg;
            m_id_reg   <= oid_reg;
            m_prio_reg <= opr_reg;
            m_occ_reg  <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ins_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_extract = (in_cmd_reg == CMD_EXTRACT);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.shift_done = (src_reg >= count_reg);
    assign stat.lt_two     = (count_reg < CNT_W'(2));
    assign stat.moved      = moved;
    assign stat.deeper     = (best_left_x < count_x);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_sts_reg;
    assign m_tdata  = M_TDATA_W'({m_occ_reg, m_prio_reg, m_id_reg});

endmodule

`default_nettype wire

FILE: src/max_heap_priority_queue.sv
`default_nettype none

// channel  dir  tdata (low bit up)                  tuser          tlast
// s_axis   in   item_id[15:0], item_priority[31:16]  cmd[0]         -
// m_axis   out  out_id[15:0], out_priority[31:16],    status[1:0]    -
//               occupancy[32 +: CNT_W], zero pad
//
// One item at a time: s_axis_tready is high only while the queue is idle.
// Insert appends and rebuilds; extract takes the root, shifts the rest down one slot, rebuilds.
// Rebuild sinks nodes (count-1)/2 down to 0 as far as needed, count taken after the change.
// Rejected operations (empty extract, full insert) go straight from decode to the result.
// Synchronous active-low reset empties the queue; the RAM is not cleared.
// A result waiting on m_axis_tready holds the next operation at its final beat.

module max_heap_priority_queue #(
    parameter int CAPACITY   = hmpq_pkg::DEF_CAPACITY,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((32 + CNT_W + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // item_id [15:0], item_priority [31:16]
    input  wire logic [hmpq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd [0]
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // out_id [15:0], out_priority [31:16], occupancy [32 +: CNT_W]
    output logic      [M_TDATA_W-1:0]           m_axis_tdata,
    // status [1:0]
    output logic      [1:0]                     m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready
);
    import hmpq_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    // sequencer: decode, append / shift, bottom-up rebuild, result hand-off
    hmpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    // heap RAM, count, sift registers and the output register
    hmpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat)
    );

endmodule

`default_nettype wire

FILE: src/hmpq_checker.sv
`default_nettype none

`include "max_heap_priority_queue_defines.svh"

module hmpq_checker #(
    parameter int CAPACITY   = hmpq_pkg::DEF_CAPACITY,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((32 + CNT_W + 7) / 8) * 8
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic [hmpq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                           s_axis_tuser,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [M_TDATA_W-1:0]           m_axis_tdata,
    input wire logic [1:0]                     m_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready
);
    import hmpq_pkg::*;

    `HMPQ_ASSERT_RST(a_reset_no_beat, aclk, !aresetn |=> !m_axis_tvalid, "result after reset")

    `HMPQ_ASSERT(a_busy_after_accept, aclk, aresetn, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item taken while busy")

    `HMPQ_ASSERT(a_occ_range, aclk, aresetn, m_axis_tvalid |-> (m_axis_tdata[32 +: CNT_W] <= CNT_W'(CAPACITY)), "occupancy above capacity")

    `HMPQ_ASSERT(a_zero_payload, aclk, aresetn, (m_axis_tvalid && (m_axis_tuser != STS_EXTRACTED)) |-> (m_axis_tdata[31:0] == 32'd0), "payload on non-extract result")

    `HMPQ_ASSERT(a_flag_occ, aclk, aresetn, (m_axis_tvalid && ((m_axis_tuser == STS_EMPTY) || (m_axis_tuser == STS_FULL))) |-> ((m_axis_tuser == STS_EMPTY) ? (m_axis_tdata[32 +: CNT_W] == '0) : (m_axis_tdata[32 +: CNT_W] == CNT_W'(CAPACITY))), "flag disagrees with occupancy")

    // spare inputs kept on the bind for completeness
    logic unused_in;
    assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind max_heap_priority_queue hmpq_checker #(.CAPACITY(CAPACITY)) u_hmpq_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

import hmpq_pkg::*;

// occupancy field width, as the block sizes it for its default depth
localparam int OCC_W = $clog2(DEF_CAPACITY + 1);
localparam int M_W   = ((32 + OCC_W + 7) / 8) * 8;

typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occupancy;
} heap_result_t;

// Mirror of the queue plus the list of result beats still owed by the block.
class heap_scoreboard;
    entry_t       slots [DEF_CAPACITY];
    int unsigned  held;
    heap_result_t awaited [$];
    int unsigned  errors;

    function new();
        held   = 0;
        errors = 0;
        foreach (slots[i]) slots[i] = '0;
    endfunction

    // strict greater-than, left child wins a tie
    function void sift_from(int unsigned pos, int unsigned n);
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        entry_t      tmp;
        bit          moving;
        moving = 1'b1;
        while (moving) begin
            lc   = 2 * pos + 1;
            rc   = lc + 1;
            best = pos;
            if (lc < n && slots[lc].prio > slots[best].prio) best = lc;
            if (rc < n && slots[rc].prio > slots[best].prio) best = rc;
            if (best == pos) begin
                moving = 1'b0;
            end else begin
                tmp         = slots[pos];
                slots[pos]  = slots[best];
                slots[best] = tmp;
                pos         = best;
            end
        end
    endfunction

    function void rebuild_heap();
        int i;
        if (held < 2) return;
        for (i = int'((held - 1) / 2); i >= 0; i--) sift_from(i, held);
    endfunction

    function void note_beat(cmd_t cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        heap_result_t r;
        int unsigned  i;
        r = '0;
        if (cmd == CMD_INSERT) begin
            if (held >= DEF_CAPACITY) begin
                r.status = STS_FULL;
            end else begin
                slots[held].id   = id;
                slots[held].prio = prio;
                held++;
                rebuild_heap();
                r.status = STS_INSERTED;
            end
        end else begin
            if (held == 0) begin
                r.status = STS_EMPTY;
            end else begin
                r.id   = slots[0].id;
                r.prio = slots[0].prio;
                for (i = 0; i + 1 < held; i++) slots[i] = slots[i + 1];
                held--;
                rebuild_heap();
                r.status = STS_EXTRACTED;
            end
        end
        r.occupancy = OCC_W'(held);
        awaited.push_back(r);
    endfunction

    function void check_beat(logic [1:0] status, logic [ID_W-1:0] id,
                             logic [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
        heap_result_t w;
        if (awaited.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d", status);
            errors++;
            return;
        end
        w = awaited.pop_front();
        if (status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status);
            errors++;
        end
        if (id !== w.id) begin
            $error("out_id: expected %h, got %h", w.id, id);
            errors++;
        end
        if (prio !== w.prio) begin
            $error("out_priority: expected %h, got %h", w.prio, prio);
            errors++;
        end
        if (occ !== w.occupancy) begin
            $error("occupancy: expected %0d, got %0d", w.occupancy, occ);
            errors++;
        end
    endfunction
endclass

module tb_top;

    // random items after the directed opener
    localparam int unsigned RANDOM_ITEMS = 1600;
    // idle cycles tolerated with no beat on either side
    localparam int unsigned STALL_LIMIT  = 20000;
    // drain time after the last result, roughly one worst-case operation
    localparam int unsigned TAIL_CYCLES  = 600;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_W-1:0]       m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    heap_scoreboard sb = new();

    int unsigned items_sent   = 0;
    bit          sender_quiet = 1'b0;
    int unsigned stall_cycles = 0;

    max_heap_priority_queue #(
        .CAPACITY(DEF_CAPACITY)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),   // item_id [15:0], item_priority [31:16]
        .s_axis_tuser (s_axis_tuser),   // cmd [0]
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // out_id, out_priority, occupancy, zero pad
        .m_axis_tuser (m_axis_tuser),   // status [1:0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Both channels are sampled at the edge; everything the testbench drives
    // changes by NBA, so these are the values the block saw at that edge.
    // The input beat is noted first, though a result never shares the edge
    // of the beat that caused it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_beat(cmd_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                              m_axis_tdata[32 +: OCC_W]);
        end
    end

    // Watchdog: counts edges with no beat on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, two long hold-offs so the block sits
    // on a finished result and refuses input, and tready stuck high while the
    // sender runs without gaps.
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc       = 0;
        hold_left = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (cyc == 2500 || cyc == 90000) hold_left = 600;
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (sender_quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 12);
            end
            @(posedge aclk);
            cyc++;
        end
    end

    // Offers one beat and returns at the edge it is taken. About one beat in
    // eight is preceded by a gap of random length, long enough at times to
    // overlap any stage of the operation in flight. tvalid stays high
    // straight into the next beat when there is no gap.
    task automatic send_beat(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio);
        int unsigned gap;
        gap = 0;
        if (!sender_quiet && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 160);
        while (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
            gap--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {prio, id};
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Mostly spread over the full range, with a share of tiny values for
    // ties and of the two extremes.
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0:       return PRIO_W'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    // extract on empty, extreme ids and priorities, three-way tie on
    // priority, drain past empty, ignored payload on extract
    task automatic run_directed();
        send_beat(CMD_EXTRACT, 16'h0000, 16'h0000);
        send_beat(CMD_INSERT,  16'h0000, 16'h0000);
        send_beat(CMD_INSERT,  16'hFFFF, 16'hFFFF);
        send_beat(CMD_INSERT,  16'h1234, 16'h8000);
        send_beat(CMD_INSERT,  16'h0001, 16'h8000);
        send_beat(CMD_INSERT,  16'h0002, 16'h8000);
        send_beat(CMD_INSERT,  16'hAAAA, 16'h0001);
        send_beat(CMD_INSERT,  16'h5555, 16'hFFFE);
        repeat (8) send_beat(CMD_EXTRACT, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_INSERT,  16'h00FF, 16'h7FFF);
        send_beat(CMD_EXTRACT, 16'h5A5A, 16'hA5A5);
    endtask

    // Runs of fill-heavy, drain-heavy and balanced traffic. The first run is
    // long and nearly all inserts, so the queue reaches full and rejects a
    // few. A stretch in the middle goes without sender gaps.
    task automatic run_random(input int unsigned target);
        int unsigned kind;
        int unsigned run_len;
        int unsigned n;
        int unsigned insert_pct;
        bit          first;
        first = 1'b1;
        while (items_sent < target) begin
            if (first) begin
                insert_pct = 95;
                run_len    = 90;
                first      = 1'b0;
            end else begin
                kind       = $urandom_range(0, 2);
                insert_pct = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
                run_len    = $urandom_range(20, 120);
            end
            for (n = 0; n < run_len && items_sent < target; n++) begin
                sender_quiet = (items_sent >= 700 && items_sent < 1000);
                if ($urandom_range(0, 99) < insert_pct)
                    send_beat(CMD_INSERT, ID_W'($urandom), pick_prio());
                else
                    send_beat(CMD_EXTRACT, ID_W'($urandom), PRIO_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(items_sent + RANDOM_ITEMS);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("tb_top OK");
        end else begin
            if (sb.awaited.size() != 0)
                $error("%0d result beats never arrived", sb.awaited.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
